[hw/rtl/bssa_pkg.sv]
// Shared constants, codes and divider handshake types for the bounded stack unit.
// Used by the top level, the divider and the port checker; depends on nothing.
package bssa_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = DATA_W + $clog2(CAPACITY);
    localparam int HELD_W   = 5;
    localparam int ST_W     = 2;
    localparam int CMD_W    = 2;
    localparam int OUT_TDATA_W = ((DATA_W + HELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - DATA_W - HELD_W;

    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SORT = 2'd2;
    localparam logic [CMD_W-1:0] CMD_AVG  = 2'd3;

    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] dividend;
        logic [CNT_W-1:0]        divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } t_div_rsp;

endpackage

[hw/rtl/bssa_div.sv]
// Signed-by-unsigned restoring divider, one quotient bit per cycle.
// Depends on bssa_pkg for widths and the request/response structs.
module bssa_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bssa_pkg::t_div_req i_req,
    output bssa_pkg::t_div_rsp o_rsp
);
    import bssa_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    logic               r_busy;
    logic               r_fix;
    logic               r_done;
    logic               r_neg;
    logic [STEP_W-1:0]  r_step;
    logic [SUM_W-1:0]   r_q;
    logic [CNT_W-1:0]   r_rem;
    logic [CNT_W-1:0]   r_div;
    logic [SUM_W-1:0]   r_quot;

    logic [CNT_W:0]     w_shift;
    logic [CNT_W:0]     w_diff;
    logic               w_ge;

    // The partial remainder always stays below the divisor, so one extra bit
    // is enough for the shifted value.
    assign w_shift = {r_rem, r_q[SUM_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_div});
    assign w_diff  = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_fix  <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_step == '0)) begin
                r_busy <= 1'b0;
                r_fix  <= 1'b1;
            end
            if (r_fix) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg  <= i_req.dividend[SUM_W-1];
            r_q    <= i_req.dividend[SUM_W-1] ? (-i_req.dividend) : i_req.dividend;
            r_rem  <= '0;
            r_div  <= i_req.divisor;
            r_step <= STEP_W'(SUM_W - 1);
        end else if (r_busy) begin
            r_q    <= {r_q[SUM_W-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[CNT_W-1:0] : w_shift[CNT_W-1:0];
            r_step <= r_step - 1'b1;
        end
        if (r_fix) begin
            r_quot <= r_neg ? (-r_q) : r_q;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quot;

endmodule

[hw/rtl/bounded_stack_sort_average_unit.sv]
// Each command runs from idle to the finish state: pop reads, sort loads, compares and
// writes back, average sums and divides; push, empty and trivial commands finish at once.
// Throughput: one item at a time; the stack memory port and the serial divider set the pace.
// A finished item waits in the output register while the next item is already accepted.
// Reset (synchronous, active low) empties the stack and drops any pending result.
// Stack contents are not cleared; only entries below the fill count are ever read.
module bounded_stack_sort_average_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input item: tdata = push_value[31:0]; tuser = cmd[1:0].
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [bssa_pkg::DATA_W-1:0]      i_s_axis_tdata,
    input  logic [bssa_pkg::CMD_W-1:0]       i_s_axis_tuser,
    // Result item: tdata = result_value[31:0], entries_held[36:32], zero pad;
    // tuser = status[1:0].
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [bssa_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic [bssa_pkg::ST_W-1:0]        o_m_axis_tuser
);
    import bssa_pkg::*;

    // Sequencer states.
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_POP     = 4'd1;
    localparam logic [3:0] S_SRT_LD  = 4'd2;
    localparam logic [3:0] S_SRT_CMP = 4'd3;
    localparam logic [3:0] S_SRT_WB  = 4'd4;
    localparam logic [3:0] S_AVG_ACC = 4'd5;
    localparam logic [3:0] S_AVG_GO  = 4'd6;
    localparam logic [3:0] S_AVG_DIV = 4'd7;
    localparam logic [3:0] S_FIN     = 4'd8;

    // Stack storage: one write port and one registered read port.
    logic [DATA_W-1:0] mem [CAPACITY];
    logic [DATA_W-1:0] r_rdata;

    logic [3:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ADDR_W-1:0] r_i, n_i;
    logic [ADDR_W-1:0] r_j, n_j;
    logic [DATA_W-1:0] r_cur, n_cur;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [DATA_W-1:0] r_res, n_res;
    logic [ST_W-1:0]   r_st, n_st;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_res;
    logic [ST_W-1:0]   r_out_st;
    logic [HELD_W-1:0] r_out_held;

    logic              w_in_acc;
    logic              w_out_load;
    logic              w_re;
    logic [ADDR_W-1:0] w_raddr;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [DATA_W-1:0] w_wdata;
    logic [CNT_W-1:0]  w_cnt_dec;

    t_div_req          w_div_req;
    t_div_rsp          w_div_rsp;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_cnt_dec       = r_count - 1'b1;
    assign w_out_load      = (r_state == S_FIN) && (!r_out_valid || i_m_axis_tready);

    bssa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Sequencer. Sort keeps the element at position i in r_cur and sweeps j
    // above it, swapping through the register, so each cycle needs only one
    // read and one write. The write of entry j and the read of entry j+1
    // never hit the same address, so no forwarding is needed.
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_i     = r_i;
        n_j     = r_j;
        n_cur   = r_cur;
        n_sum   = r_sum;
        n_res   = r_res;
        n_st    = r_st;
        w_re    = 1'b0;
        w_raddr = '0;
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = '0;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = r_sum;
        w_div_req.divisor  = r_count;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_st    = ST_DONE;
                    n_res   = '0;
                    n_state = S_FIN;
                    case (i_s_axis_tuser)
                        CMD_PUSH: begin
                            if (r_count >= CNT_W'(CAPACITY)) begin
                                n_st = ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = r_count[ADDR_W-1:0];
                                w_wdata = i_s_axis_tdata;
                                n_count = r_count + 1'b1;
                            end
                        end
                        CMD_POP: begin
                            if (r_count == '0) begin
                                n_st  = ST_EMPTY;
                                n_res = '1;
                            end else begin
                                n_count = w_cnt_dec;
                                w_re    = 1'b1;
                                w_raddr = w_cnt_dec[ADDR_W-1:0];
                                n_state = S_POP;
                            end
                        end
                        CMD_SORT: begin
                            if (r_count == '0) begin
                                n_st = ST_EMPTY;
                            end else if (r_count != CNT_W'(1)) begin
                                w_re    = 1'b1;
                                w_raddr = '0;
                                n_i     = '0;
                                n_state = S_SRT_LD;
                            end
                        end
                        CMD_AVG: begin
                            if (r_count == '0) begin
                                n_st = ST_EMPTY;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = '0;
                                n_j     = '0;
                                n_sum   = '0;
                                n_state = S_AVG_ACC;
                            end
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_POP: begin
                n_res   = r_rdata;
                n_state = S_FIN;
            end
            S_SRT_LD: begin
                n_cur   = r_rdata;
                n_j     = r_i + 1'b1;
                w_re    = 1'b1;
                w_raddr = r_i + 1'b1;
                n_state = S_SRT_CMP;
            end
            S_SRT_CMP: begin
                if ($signed(r_cur) > $signed(r_rdata)) begin
                    w_we    = 1'b1;
                    w_waddr = r_j;
                    w_wdata = r_cur;
                    n_cur   = r_rdata;
                end
                if ((CNT_W'(r_j) + 1'b1) < r_count) begin
                    n_j     = r_j + 1'b1;
                    w_re    = 1'b1;
                    w_raddr = r_j + 1'b1;
                end else begin
                    n_state = S_SRT_WB;
                end
            end
            S_SRT_WB: begin
                w_we    = 1'b1;
                w_waddr = r_i;
                w_wdata = r_cur;
                n_i     = r_i + 1'b1;
                if ((CNT_W'(r_i) + CNT_W'(2)) < r_count) begin
                    w_re    = 1'b1;
                    w_raddr = r_i + 1'b1;
                    n_state = S_SRT_LD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_AVG_ACC: begin
                n_sum = r_sum + {{(SUM_W - DATA_W){r_rdata[DATA_W-1]}}, r_rdata};
                if ((CNT_W'(r_j) + 1'b1) < r_count) begin
                    n_j     = r_j + 1'b1;
                    w_re    = 1'b1;
                    w_raddr = r_j + 1'b1;
                end else begin
                    n_state = S_AVG_GO;
                end
            end
            S_AVG_GO: begin
                w_div_req.start = 1'b1;
                n_state         = S_AVG_DIV;
            end
            S_AVG_DIV: begin
                if (w_div_rsp.done) begin
                    // The quotient of an exact sum always fits in one word.
                    w_we    = 1'b1;
                    w_waddr = '0;
                    w_wdata = w_div_rsp.quotient[DATA_W-1:0];
                    n_res   = w_div_rsp.quotient[DATA_W-1:0];
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i   <= n_i;
        r_j   <= n_j;
        r_cur <= n_cur;
        r_sum <= n_sum;
        r_res <= n_res;
        r_st  <= n_st;
    end

    // Output register: holds a finished item until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_res  <= r_res;
            r_out_st   <= r_st;
            r_out_held <= HELD_W'(r_count);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_held, r_out_res};
    assign o_m_axis_tuser  = r_out_st;

endmodule

[hw/rtl/bssa_chk.sv]
// Port-level checker for the bounded stack unit, bound to the top level.
// Depends on bssa_pkg for codes, widths and the capacity.
module bssa_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [bssa_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic [bssa_pkg::ST_W-1:0]        o_m_axis_tuser
);
    import bssa_pkg::*;

    logic [HELD_W-1:0] w_held;
    assign w_held = o_m_axis_tdata[DATA_W +: HELD_W];

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == ST_EMPTY) |-> (w_held == '0))
        else $error("empty status with entries held");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == ST_FULL) |-> (w_held == HELD_W'(CAPACITY)))
        else $error("full status without a full stack");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[OUT_TDATA_W-1 -: OUT_PAD_W] == '0))
        else $error("result padding not zero");

endmodule

bind bounded_stack_sort_average_unit bssa_chk u_bssa_chk (.*);

[tb/bssa_stack_checker.sv]
`timescale 1ns / 100ps
// Result checker for the bounded stack unit: it watches the command and result streams,
// keeps its own copy of the stack and compares every result item. Depends on bssa_pkg.
module bssa_stack_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Command stream as seen on the block's slave side.
    input  logic                             i_cmd_tvalid,
    input  logic                             i_cmd_tready,
    input  logic [bssa_pkg::DATA_W-1:0]      i_cmd_tdata,   // push_value[31:0]
    input  logic [bssa_pkg::CMD_W-1:0]       i_cmd_tuser,   // cmd[1:0]
    // Result stream as seen on the block's master side.
    input  logic                             i_res_tvalid,
    input  logic                             i_res_tready,
    // result_value[31:0], entries_held[36:32]
    input  logic [bssa_pkg::OUT_TDATA_W-1:0] i_res_tdata,
    input  logic [bssa_pkg::ST_W-1:0]        i_res_tuser,   // status[1:0]
    output int                               o_errors,
    output int                               o_outstanding
);
    import bssa_pkg::*;

    typedef struct {
        logic [ST_W-1:0]   status;
        logic [DATA_W-1:0] value;
        logic [HELD_W-1:0] held;
    } t_stack_result;

    logic signed [DATA_W-1:0] stack_mem [CAPACITY];
    int                       depth;
    t_stack_result            pending_results [$];
    t_stack_result            predicted;
    t_stack_result            oldest;
    int                       error_count;

    // Applies one command to the local stack copy and returns the result it should give.
    task automatic run_stack_command(input logic [CMD_W-1:0] code,
                                     input logic [DATA_W-1:0] word,
                                     output t_stack_result res);
        logic signed [DATA_W-1:0] swap;
        longint                   total;
        longint                   quotient;
        int                       i;
        int                       j;
        res.status = ST_DONE;
        res.value  = '0;
        case (code)
            CMD_PUSH: begin
                if (depth >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    stack_mem[depth] = word;
                    depth++;
                end
            end
            CMD_POP: begin
                if (depth == 0) begin
                    res.status = ST_EMPTY;
                    res.value  = '1;
                end else begin
                    depth--;
                    res.value = stack_mem[depth];
                end
            end
            CMD_SORT: begin
                if (depth == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    for (i = 0; i + 1 < depth; i++) begin
                        for (j = i + 1; j < depth; j++) begin
                            if (stack_mem[i] > stack_mem[j]) begin
                                swap         = stack_mem[i];
                                stack_mem[i] = stack_mem[j];
                                stack_mem[j] = swap;
                            end
                        end
                    end
                end
            end
            default: begin
                if (depth == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    // The sum is exact in 64 bits; SystemVerilog division truncates toward zero.
                    total = 0;
                    for (i = 0; i < depth; i++) begin
                        total += stack_mem[i];
                    end
                    quotient     = total / longint'(depth);
                    stack_mem[0] = quotient[DATA_W-1:0];
                    res.value    = stack_mem[0];
                end
            end
        endcase
        res.held = depth[HELD_W-1:0];
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            depth       = 0;
            error_count = 0;
            pending_results.delete();
        end else begin
            if (i_cmd_tvalid && i_cmd_tready) begin
                run_stack_command(i_cmd_tuser, i_cmd_tdata, predicted);
                pending_results.push_back(predicted);
            end
            if (i_res_tvalid && i_res_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result item with no command waiting: status %0d, value %0d",
                           i_res_tuser, $signed(i_res_tdata[DATA_W-1:0]));
                    error_count++;
                end else begin
                    oldest = pending_results.pop_front();
                    if (i_res_tuser !== oldest.status) begin
                        $error("status: expected %0d, got %0d", oldest.status, i_res_tuser);
                        error_count++;
                    end
                    if (i_res_tdata[DATA_W-1:0] !== oldest.value) begin
                        $error("result_value: expected %0d, got %0d",
                               $signed(oldest.value), $signed(i_res_tdata[DATA_W-1:0]));
                        error_count++;
                    end
                    if (i_res_tdata[DATA_W +: HELD_W] !== oldest.held) begin
                        $error("entries_held: expected %0d, got %0d",
                               oldest.held, i_res_tdata[DATA_W +: HELD_W]);
                        error_count++;
                    end
                end
            end
        end
        o_errors      <= error_count;
        o_outstanding <= pending_results.size();
    end

endmodule

[tb/bounded_stack_sort_average_unit_test.sv]
`timescale 1ns / 100ps
// Top of the bounded stack unit test: clock, reset, command stimulus and the verdict.
// Depends on bssa_pkg, the unit itself and bssa_stack_checker.
module bounded_stack_sort_average_unit_test;

    import bssa_pkg::*;

    localparam int  IDLE_PCT     = 29;
    localparam int  RANDOM_ITEMS = 650;
    // Long enough for a full sort at sixteen entries, so this covers any last item.
    localparam int  DRAIN_CYCLES = 250;
    // Slowest run: every item a full-depth sort plus long stalls on both sides, many times over.
    localparam int  CYCLE_LIMIT  = 800000;
    localparam logic [DATA_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [DATA_W-1:0]      i_s_axis_tdata;   // push_value[31:0]
    logic [CMD_W-1:0]       i_s_axis_tuser;   // cmd[1:0]
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;   // result_value[31:0], entries_held[36:32], pad
    logic [ST_W-1:0]        o_m_axis_tuser;   // status[1:0]

    int   error_total;
    int   outstanding;
    int   cycle_count;
    // While steady is high neither the command source nor the result sink idles.
    logic steady;

    bounded_stack_sort_average_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    bssa_stack_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_tvalid  (i_s_axis_tvalid),
        .i_cmd_tready  (o_s_axis_tready),
        .i_cmd_tdata   (i_s_axis_tdata),
        .i_cmd_tuser   (i_s_axis_tuser),
        .i_res_tvalid  (o_m_axis_tvalid),
        .i_res_tready  (i_m_axis_tready),
        .i_res_tdata   (o_m_axis_tdata),
        .i_res_tuser   (o_m_axis_tuser),
        .o_errors      (error_total),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = CMD_PUSH;
        i_m_axis_tready = 1'b0;
        steady          = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    // The result sink stalls at random except during the steady stretch.
    always @(posedge i_clk) begin
        i_m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("bounded_stack_sort_average_unit: mismatch");
            $finish;
        end
    end

    initial cycle_count = 0;

    // Offers one command item and returns at the edge where it is taken. A random gap
    // of idle cycles may come first; without a gap tvalid stays high from the last item.
    task automatic send_command(input logic [CMD_W-1:0] code, input logic [DATA_W-1:0] word);
        int gap;
        gap = 0;
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PCT) gap++;
        end
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= word;
        i_s_axis_tuser  <= code;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    // Push values: small signed numbers so averages stay readable, the corner words,
    // and full-range random words.
    function automatic logic [DATA_W-1:0] random_word();
        int kind;
        kind = $urandom_range(0, 3);
        case (kind)
            0: return $urandom_range(0, 40) - 20;
            1: begin
                case ($urandom_range(0, 3))
                    0:       return WORD_MAX;
                    1:       return WORD_MIN;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    initial begin
        int               i;
        int               push_pct;
        int               roll;
        logic [CMD_W-1:0] code;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Pop, sort and average on an empty stack first.
        send_command(CMD_POP, 32'h1234_5678);
        send_command(CMD_SORT, '0);
        send_command(CMD_AVG, '0);
        // Fill to capacity with the most negative and most positive words, then a one.
        // The exact sum is -2^31 - 6, so the average needs truncation toward zero
        // and a 32-bit accumulator would overflow.
        for (i = 0; i < 15; i++) begin
            send_command(CMD_PUSH, i[0] ? WORD_MAX : WORD_MIN);
        end
        send_command(CMD_PUSH, 32'd1);
        // Push on a full stack is refused.
        send_command(CMD_PUSH, 32'd5);
        send_command(CMD_AVG, '1);
        send_command(CMD_SORT, '0);
        send_command(CMD_POP, '0);
        send_command(CMD_POP, '0);
        send_command(CMD_AVG, '0);

        // Random part. The push share changes every forty items so the stack drifts
        // between empty and full and both boundaries are hit many times.
        push_pct = 50;
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 40 == 0) push_pct = $urandom_range(25, 80);
            steady <= (i >= 250 && i < 400);
            roll = $urandom_range(99);
            if (roll < 10) begin
                code = CMD_SORT;
            end else if (roll < 20) begin
                code = CMD_AVG;
            end else if ($urandom_range(99) < push_pct) begin
                code = CMD_PUSH;
            end else begin
                code = CMD_POP;
            end
            send_command(code, random_word());
        end
        i_s_axis_tvalid <= 1'b0;

        // Let the checker see the last acceptance before waiting for the results.
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_total == 0 && outstanding == 0) begin
            $display("bounded_stack_sort_average_unit: match");
        end else begin
            $display("bounded_stack_sort_average_unit: mismatch");
        end
        $finish;
    end

endmodule
